// File: rtl/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared types and constants for the rolling hash pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rhpm_pkg;

  localparam int MAX_PATTERN_D = 64;
  localparam int HASH_BITS_D   = 23;

  localparam int TEXT_W    = 8;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 23;
  localparam int LEN_CFG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 24;

  // 129 = (1 << 7) + 1
  localparam int BASE_SHIFT = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HASH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_POWER      = 2'd2;

  // flags of the word sitting in the hash stage
  typedef struct packed {
    logic full;
    logic seg;
  } s1_t;

endpackage

`default_nettype wire

// File: rtl/rhpm_cell.sv
// ----------------------------------------------------------------------------
// rhpm_cell
// One byte of the window delay line; offers its next byte when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpm_cell (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [rhpm_pkg::TEXT_W-1:0] din,
  input  wire logic                       sel,
  output logic      [rhpm_pkg::TEXT_W-1:0] q,
  output logic      [rhpm_pkg::TEXT_W-1:0] tap
);
  import rhpm_pkg::*;

  logic [TEXT_W-1:0] q_next;

  assign q_next = shift ? din : q;
  assign tap    = sel ? q_next : '0;

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// File: rtl/rhpm_core.sv
// ----------------------------------------------------------------------------
// rhpm_core
// Rolling hash update, window fill tracking and the drop-out term register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpm_core #(
  parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_D,
  parameter int HASH_BITS   = rhpm_pkg::HASH_BITS_D,
  localparam int LW         = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic                        seg,
  input  wire logic [rhpm_pkg::TEXT_W-1:0] text_byte,
  input  wire logic [rhpm_pkg::TEXT_W-1:0] tap_next,
  input  wire logic [HASH_BITS-1:0]        top_next,
  input  wire logic [LW-1:0]               len_eff,
  output logic      [HASH_BITS-1:0]        rolling,
  output rhpm_pkg::s1_t                    flags
);
  import rhpm_pkg::*;

  logic [HASH_BITS-1:0]   term;
  logic [HASH_BITS-1:0]   gone_ext;
  logic [2*HASH_BITS-1:0] prod;
  logic [HASH_BITS-1:0]   byte_ext;
  logic [HASH_BITS-1:0]   h0, h1, h2;
  logic [LW-1:0]          fill, fill0, fill_next;
  logic                   full_pre;

  // term for the word after this cycle, from next window state and config
  assign gone_ext = HASH_BITS'($signed(tap_next));
  assign prod     = gone_ext * top_next;

  always_ff @(posedge clk) begin
    term <= prod[HASH_BITS-1:0];
  end

  assign byte_ext = HASH_BITS'($signed(text_byte));

  always_comb begin
    fill0     = seg ? '0 : fill;
    h0        = seg ? '0 : rolling;
    full_pre  = fill0 >= len_eff;
    h1        = full_pre ? h0 - term : h0;
    h2        = (h1 << BASE_SHIFT) + h1 + byte_ext;
    fill_next = full_pre ? fill0 : fill0 + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling <= '0;
      fill    <= '0;
    end else if (accept) begin
      rolling <= h2;
      fill    <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags.full <= fill_next >= len_eff;
      flags.seg  <= seg;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rolling_hash_pattern_matcher.sv
// ----------------------------------------------------------------------------
// rolling_hash_pattern_matcher
// Rolling hash search over a signed byte stream with saturating match count.
// ----------------------------------------------------------------------------
// An accepted input word passes the hash stage, then the compare and count stage.
// Throughput: one word per cycle while m_tready does not stall the output.
// The drop-out term is precomputed into a register from the next delay line state.
// Reset clears hash, fill, count, handshake state and loads the register
// defaults (target 0, length 1, top power 1). No clearing pass.
`default_nettype none

module rolling_hash_pattern_matcher #(
  parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_D,
  parameter int HASH_BITS   = rhpm_pkg::HASH_BITS_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rhpm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rhpm_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rhpm_pkg::TEXT_W-1:0]    s_tdata,  // [7:0] text_byte
  input  wire logic                           s_tuser,  // [0] segment_start
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [rhpm_pkg::OUT_W-1:0]     m_tdata   // [0] match, [16:1] match_total
);
  import rhpm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [CFG_W-1:0]     target_hash, top_power;
  logic [CFG_W-1:0]     top_power_next;
  logic [LW-1:0]        len_eff, len_next;
  logic [LEN_CFG_W-1:0] len_raw;
  logic [HASH_BITS-1:0] target_h, top_next;

  logic                 accept, adv, s1_valid, o_valid;
  logic [HASH_BITS-1:0] rolling;
  s1_t                  flags;

  logic [MAX_PATTERN-1:0] sel_next;
  logic [TEXT_W-1:0]      q   [MAX_PATTERN];
  logic [TEXT_W-1:0]      din [MAX_PATTERN];
  logic [TEXT_W-1:0]      tap [MAX_PATTERN];
  logic [TEXT_W-1:0]      tap_or;

  logic             hit, o_match;
  logic [CNT_W-1:0] cnt, cnt0, cnt_next;

  // config registers; length is kept clamped to 1..MAX_PATTERN
  assign len_raw = cfg_wdata[LEN_CFG_W-1:0];

  always_comb begin
    len_next       = len_eff;
    top_power_next = top_power;
    if (cfg_we && cfg_idx == CFG_PATTERN_LENGTH) begin
      if (len_raw == '0) begin
        len_next = LW'(1);
      end else if (int'(len_raw) > MAX_PATTERN) begin
        len_next = LW'(MAX_PATTERN);
      end else begin
        len_next = LW'(len_raw);
      end
    end
    if (cfg_we && cfg_idx == CFG_TOP_POWER) begin
      top_power_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_hash <= '0;
      len_eff     <= LW'(1);
      top_power   <= CFG_W'(1);
    end else begin
      if (cfg_we && cfg_idx == CFG_TARGET_HASH) begin
        target_hash <= cfg_wdata;
      end
      len_eff   <= len_next;
      top_power <= top_power_next;
    end
  end

  assign target_h = HASH_BITS'(target_hash);
  assign top_next = HASH_BITS'(top_power_next);

  // handshake
  assign adv      = s1_valid && (!o_valid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !adv);
      o_valid  <= adv || (o_valid && !m_tready);
    end
  end

  // window delay line: cell 0 holds the newest byte
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign sel_next[i] = (len_next == LW'(i + 1));
    if (i == 0) begin : g_head
      assign din[i] = s_tdata;
    end else begin : g_body
      assign din[i] = q[i-1];
    end
    rhpm_cell u_cell (
      .clk   (clk),
      .shift (accept),
      .din   (din[i]),
      .sel   (sel_next[i]),
      .q     (q[i]),
      .tap   (tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      tap_or = tap_or | tap[i];
    end
  end

  rhpm_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .HASH_BITS   (HASH_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .seg       (s_tuser),
    .text_byte (s_tdata),
    .tap_next  (tap_or),
    .top_next  (top_next),
    .len_eff   (len_eff),
    .rolling   (rolling),
    .flags     (flags)
  );

  // compare and count stage
  always_comb begin
    hit      = flags.full && (rolling == target_h);
    cnt0     = flags.seg ? '0 : cnt;
    cnt_next = (hit && cnt0 != COUNT_MAX) ? cnt0 + CNT_W'(1) : cnt0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (adv) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_match <= hit;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {(OUT_W - CNT_W - 1)'(0), cnt, o_match};

  // checks
  a_sel_onehot : assert property (@(posedge clk) disable iff (rst) $onehot(sel_next))
    else $error("window tap select not one-hot");

  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(rolling) && $stable(flags))
    else $error("hash stage changed while stalled");

  a_match_count : assert property (@(posedge clk) disable iff (rst)
    o_valid && o_match |-> cnt != '0)
    else $error("match reported with zero count");

  a_cnt_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cnt))
    else $error("count moved without a word");

endmodule

`default_nettype wire
